[hw/rtl/pms_pkg.sv]
// pms_pkg: types, codes and constants of the pusher motor sequencer.
// Used by all modules; no dependencies.
package pms_pkg;

    localparam logic [7:0] SPEED_FULL    = 8'd255;
    localparam logic [7:0] SPEED_HOMING  = 8'd160;
    localparam logic [7:0] SPEED_SLOW    = 8'd80;
    localparam logic [7:0] SPEED_REVERSE = 8'd100;
    localparam logic [2:0] QUIET_MAX     = 3'd7;
    localparam logic [15:0] DARTS_MAX    = 16'hFFFF;

    localparam logic [7:0] COUNT_TARGET_RESET   = 8'd0;
    localparam logic [2:0] DEBOUNCE_RESET       = 3'd5;
    localparam logic [7:0] BACK_BRAKE_RESET     = 8'd200;
    localparam logic [7:0] FRONT_BRAKE_RESET    = 8'd100;

    typedef enum logic [2:0] {
        ST_INACTIVE  = 3'd0,
        ST_STARTING  = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_RETURNING = 3'd3,
        ST_BRAKING   = 3'd4,
        ST_STOPPED   = 3'd5
    } op_state_t;

    typedef enum logic [2:0] {
        POS_UNKNOWN     = 3'd0,
        POS_FRONT       = 3'd1,
        POS_AFTER_FRONT = 3'd2,
        POS_BACK        = 3'd3,
        POS_AFTER_BACK  = 3'd4,
        POS_HOMING      = 3'd5,
        POS_SLOW_RETURN = 3'd6
    } pos_t;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_BACK  = 3'd3,
        OP_FRONT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_COUNT_TARGET = 2'd0,
        CFG_DEBOUNCE     = 2'd1,
        CFG_BACK_BRAKE   = 2'd2,
        CFG_FRONT_BRAKE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] count_target;
        logic [2:0] debounce_ms;
        logic [7:0] back_brake_ms;
        logic [7:0] front_brake_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0] operation;
        logic       sensor_level;
        logic       launcher_ready;
    } in_item_t;

    typedef struct packed {
        op_state_t   op_state;
        pos_t        disc_position;
        logic [15:0] darts;
        logic [7:0]  brake_timer;
        logic [2:0]  back_quiet;
        logic [2:0]  front_quiet;
        logic        pin_a;
        logic        pin_b;
        logic [7:0]  duty;
        logic        standby_level;
    } seq_state_t;

endpackage

[hw/rtl/pms_channels.sv]
// pms_in_if / pms_out_if: valid/ready item channels of the sequencer.
// Payload fields follow pms_pkg widths; no dependencies.
interface pms_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic       sensor_level;
    logic       launcher_ready;

    modport source (output valid, output operation, output sensor_level,
                    output launcher_ready, input ready);
    modport sink   (input valid, input operation, input sensor_level,
                    input launcher_ready, output ready);
endinterface

interface pms_out_if;
    logic        valid;
    logic        ready;
    logic        drive_in1;
    logic        drive_in2;
    logic [7:0]  drive_speed;
    logic        standby_out;
    logic [2:0]  operating_state;
    logic [2:0]  position_code;
    logic [15:0] dart_count;

    modport source (output valid, output drive_in1, output drive_in2,
                    output drive_speed, output standby_out, output operating_state,
                    output position_code, output dart_count, input ready);
    modport sink   (input valid, input drive_in1, input drive_in2,
                    input drive_speed, input standby_out, input operating_state,
                    input position_code, input dart_count, output ready);
endinterface

[hw/rtl/pms_cfg_regs.sv]
// pms_cfg_regs: configuration registers behind the plain write port.
// Depends on pms_pkg.
module pms_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                we,
    input  logic [1:0]          index,
    input  logic [7:0]          data,
    output pms_pkg::cfg_t       cfg
);

    pms_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count_target   <= pms_pkg::COUNT_TARGET_RESET;
            cfg_reg.debounce_ms    <= pms_pkg::DEBOUNCE_RESET;
            cfg_reg.back_brake_ms  <= pms_pkg::BACK_BRAKE_RESET;
            cfg_reg.front_brake_ms <= pms_pkg::FRONT_BRAKE_RESET;
        end
        else if (we)
        begin
            unique case (pms_pkg::cfg_idx_t'(index))
                pms_pkg::CFG_COUNT_TARGET: cfg_reg.count_target   <= data;
                pms_pkg::CFG_DEBOUNCE:     cfg_reg.debounce_ms    <= data[2:0];
                pms_pkg::CFG_BACK_BRAKE:   cfg_reg.back_brake_ms  <= data;
                pms_pkg::CFG_FRONT_BRAKE:  cfg_reg.front_brake_ms <= data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/pms_step.sv]
// pms_step: next sequencer state for one item (tick, start, stop, sensor change).
// Depends on pms_pkg.
module pms_step (
    input  pms_pkg::cfg_t      cfg,
    input  pms_pkg::seq_state_t cur,
    input  pms_pkg::in_item_t  item,
    output pms_pkg::seq_state_t nxt
);

    logic target_set;
    logic target_reached;

    assign target_set     = (cfg.count_target != 8'd0);
    assign target_reached = (cur.darts >= {8'd0, cfg.count_target});

    always_comb
    begin
        nxt = cur;
        unique case (pms_pkg::op_t'(item.operation))
            pms_pkg::OP_TICK:
            begin
                if (cur.brake_timer != 8'd0)
                    nxt.brake_timer = cur.brake_timer - 8'd1;
                if (cur.back_quiet < pms_pkg::QUIET_MAX)
                    nxt.back_quiet = cur.back_quiet + 3'd1;
                if (cur.front_quiet < pms_pkg::QUIET_MAX)
                    nxt.front_quiet = cur.front_quiet + 3'd1;
                unique case (cur.op_state)
                    pms_pkg::ST_STARTING:
                    begin
                        if (item.launcher_ready)
                        begin
                            nxt.duty     = pms_pkg::SPEED_FULL;
                            nxt.pin_a    = 1'b1;
                            nxt.pin_b    = 1'b0;
                            nxt.op_state = pms_pkg::ST_RUNNING;
                        end
                    end
                    pms_pkg::ST_RUNNING:
                    begin
                        if (target_set && target_reached)
                            nxt.op_state = pms_pkg::ST_RETURNING;
                    end
                    pms_pkg::ST_RETURNING:
                    begin
                        if (cur.disc_position == pms_pkg::POS_UNKNOWN)
                        begin
                            nxt.duty          = pms_pkg::SPEED_HOMING;
                            nxt.pin_a         = 1'b1;
                            nxt.pin_b         = 1'b0;
                            nxt.standby_level = 1'b1;
                            nxt.disc_position = pms_pkg::POS_HOMING;
                        end
                        else if (cur.disc_position == pms_pkg::POS_AFTER_FRONT
                                 && nxt.brake_timer == 8'd0)
                        begin
                            nxt.duty          = pms_pkg::SPEED_SLOW;
                            nxt.pin_a         = 1'b1;
                            nxt.pin_b         = 1'b0;
                            nxt.disc_position = pms_pkg::POS_SLOW_RETURN;
                        end
                    end
                    pms_pkg::ST_BRAKING:
                    begin
                        if (nxt.brake_timer == 8'd0)
                        begin
                            nxt.pin_a = 1'b0;
                            nxt.pin_b = 1'b0;
                            if (cur.disc_position == pms_pkg::POS_BACK)
                                nxt.op_state = pms_pkg::ST_STOPPED;
                        end
                    end
                    pms_pkg::ST_STOPPED:
                    begin
                        nxt.op_state = pms_pkg::ST_INACTIVE;
                        nxt.darts    = 16'd0;
                    end
                    default: ;
                endcase
            end
            pms_pkg::OP_START:
            begin
                nxt.op_state = pms_pkg::ST_STARTING;
                nxt.darts    = 16'd0;
            end
            pms_pkg::OP_STOP:
            begin
                if ((cur.op_state == pms_pkg::ST_INACTIVE
                     || cur.op_state == pms_pkg::ST_STARTING
                     || cur.op_state == pms_pkg::ST_RUNNING)
                    && !(target_set && !target_reached))
                    nxt.op_state = pms_pkg::ST_RETURNING;
            end
            pms_pkg::OP_BACK:
            begin
                if (cur.back_quiet >= cfg.debounce_ms)
                begin
                    nxt.back_quiet = 3'd0;
                    if (!item.sensor_level)
                    begin
                        nxt.disc_position = pms_pkg::POS_BACK;
                        if (cur.op_state == pms_pkg::ST_RETURNING)
                        begin
                            nxt.op_state    = pms_pkg::ST_BRAKING;
                            nxt.pin_a       = 1'b1;
                            nxt.pin_b       = 1'b1;
                            nxt.brake_timer = cfg.back_brake_ms;
                        end
                    end
                    else
                    begin
                        nxt.disc_position = pms_pkg::POS_AFTER_BACK;
                        if (cur.op_state == pms_pkg::ST_BRAKING)
                        begin
                            nxt.op_state = pms_pkg::ST_RETURNING;
                            nxt.duty     = pms_pkg::SPEED_REVERSE;
                            nxt.pin_a    = 1'b0;
                            nxt.pin_b    = 1'b1;
                        end
                    end
                end
            end
            pms_pkg::OP_FRONT:
            begin
                if (cur.front_quiet >= cfg.debounce_ms)
                begin
                    nxt.front_quiet = 3'd0;
                    if (!item.sensor_level)
                    begin
                        nxt.disc_position = pms_pkg::POS_FRONT;
                        if (cur.darts != pms_pkg::DARTS_MAX)
                            nxt.darts = cur.darts + 16'd1;
                    end
                    else
                    begin
                        nxt.disc_position = pms_pkg::POS_AFTER_FRONT;
                        if (cur.op_state == pms_pkg::ST_RETURNING)
                        begin
                            nxt.pin_a       = 1'b1;
                            nxt.pin_b       = 1'b1;
                            nxt.brake_timer = cfg.front_brake_ms;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/pusher_motor_sequencer_top.sv]
// pusher_motor_sequencer_top: input register, state update and result register.
// Depends on pms_pkg, pms_channels, pms_cfg_regs and pms_step.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    operation, sensor_level, launcher_ready
//   out_ch    out  valid/ready    drive_in1/2, drive_speed, standby_out,
//                                 operating_state, position_code, dart_count
//   cfg_*     in   cfg_we only    cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; each item passes the input register and then the result register.
// The state update is a single pass through pms_step between the input
// register and the result register. Reset is asynchronous, active low;
// no clearing pass. A stalled output holds the result and, once the input
// register is full too, drops in_ch.ready.
module pusher_motor_sequencer_top (
    input  logic       clk,
    input  logic       rst_n,
    pms_in_if.sink     in_ch,
    pms_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    pms_pkg::cfg_t       cfg;
    pms_pkg::in_item_t   item_reg;
    logic                item_valid_reg;
    pms_pkg::seq_state_t state_reg;
    pms_pkg::seq_state_t state_next;
    pms_pkg::seq_state_t result_reg;
    logic                result_valid_reg;
    logic                advance;

    pms_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    pms_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next)
    );

    assign advance     = item_valid_reg && (!result_valid_reg || out_ch.ready);
    assign in_ch.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ch.ready)
            item_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg.operation      <= in_ch.operation;
            item_reg.sensor_level   <= in_ch.sensor_level;
            item_reg.launcher_ready <= in_ch.launcher_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.op_state      <= pms_pkg::ST_RETURNING;
            state_reg.disc_position <= pms_pkg::POS_UNKNOWN;
            state_reg.darts         <= 16'd0;
            state_reg.brake_timer   <= 8'd0;
            state_reg.back_quiet    <= 3'd0;
            state_reg.front_quiet   <= 3'd0;
            state_reg.pin_a         <= 1'b0;
            state_reg.pin_b         <= 1'b0;
            state_reg.duty          <= 8'd0;
            state_reg.standby_level <= 1'b1;
        end
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (out_ch.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= state_next;
    end

    assign out_ch.valid           = result_valid_reg;
    assign out_ch.drive_in1       = result_reg.pin_a;
    assign out_ch.drive_in2       = result_reg.pin_b;
    assign out_ch.drive_speed     = result_reg.duty;
    assign out_ch.standby_out     = result_reg.standby_level;
    assign out_ch.operating_state = result_reg.op_state;
    assign out_ch.position_code   = result_reg.disc_position;
    assign out_ch.dart_count      = result_reg.darts;

`ifndef SYNTH
    // an item taken into an empty pipe reaches out_ch.valid through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !item_valid_reg && !result_valid_reg)
        |=> ##1 out_ch.valid)
        else $error("item lost in empty pipe");

    // a running brake timer in braking keeps the bridge shorted
    a_brake_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.op_state == pms_pkg::ST_BRAKING && state_reg.brake_timer != 8'd0)
        |-> (state_reg.pin_a && state_reg.pin_b))
        else $error("braking without brake drive");

    // state moves only with an item passing to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");
`endif

endmodule

[sim/tb_pusher_motor_sequencer_top.sv]
// tb_pusher_motor_sequencer_top: self-checking testbench for the pusher motor sequencer.
// Drives items through pms_in_if, predicts every result, checks it on pms_out_if.
// Depends on pms_pkg, pms_channels and pusher_motor_sequencer_top.
module tb_pusher_motor_sequencer_top;

    localparam logic [2:0] OP_UNUSED_LO   = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI   = 3'd7;
    localparam int unsigned RANDOM_ITEMS  = 400;
    localparam int unsigned HOLD_CYCLES   = 120;
    localparam int unsigned WATCHDOG_LIMIT = 1500;
    localparam int unsigned HOME_GUARD    = 2000;

    typedef struct {
        logic                 in1;
        logic                 in2;
        logic [7:0]           speed;
        logic                 standby;
        pms_pkg::op_state_t   state;
        pms_pkg::pos_t        pos;
        logic [15:0]          count;
    } drive_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    pms_in_if  in_ch();
    pms_out_if out_ch();

    pusher_motor_sequencer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    pms_pkg::seq_state_t motor;
    pms_pkg::cfg_t       cfg_shadow;
    drive_result_t       expected_drive_q[$];

    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned burst_count     = 0;
    int unsigned setting_count   = 0;
    int unsigned hold_count      = 0;
    int unsigned no_gap_left     = 0;
    int unsigned idle_cycles     = 0;
    bit          hold_req        = 1'b0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Advances the predicted sequencer by one item and returns the result it drives.
    function automatic drive_result_t predict_motor_step(input logic [2:0] op, input logic level,
                                                         input logic ready_in);
        drive_result_t r;
        case (op)
            pms_pkg::OP_TICK:
            begin
                if (motor.brake_timer != 0)
                    motor.brake_timer--;
                if (motor.back_quiet < pms_pkg::QUIET_MAX)
                    motor.back_quiet++;
                if (motor.front_quiet < pms_pkg::QUIET_MAX)
                    motor.front_quiet++;
                case (motor.op_state)
                    pms_pkg::ST_STARTING:
                        if (ready_in)
                        begin
                            motor.duty     = pms_pkg::SPEED_FULL;
                            motor.pin_a    = 1'b1;
                            motor.pin_b    = 1'b0;
                            motor.op_state = pms_pkg::ST_RUNNING;
                        end
                    pms_pkg::ST_RUNNING:
                        if (cfg_shadow.count_target != 0 &&
                            motor.darts >= 16'(cfg_shadow.count_target))
                            motor.op_state = pms_pkg::ST_RETURNING;
                    pms_pkg::ST_RETURNING:
                        if (motor.disc_position == pms_pkg::POS_UNKNOWN)
                        begin
                            motor.duty          = pms_pkg::SPEED_HOMING;
                            motor.pin_a         = 1'b1;
                            motor.pin_b         = 1'b0;
                            motor.standby_level = 1'b1;
                            motor.disc_position = pms_pkg::POS_HOMING;
                        end
                        else if (motor.disc_position == pms_pkg::POS_AFTER_FRONT &&
                                 motor.brake_timer == 0)
                        begin
                            motor.duty          = pms_pkg::SPEED_SLOW;
                            motor.pin_a         = 1'b1;
                            motor.pin_b         = 1'b0;
                            motor.disc_position = pms_pkg::POS_SLOW_RETURN;
                        end
                    pms_pkg::ST_BRAKING:
                        if (motor.brake_timer == 0)
                        begin
                            motor.pin_a = 1'b0;
                            motor.pin_b = 1'b0;
                            if (motor.disc_position == pms_pkg::POS_BACK)
                                motor.op_state = pms_pkg::ST_STOPPED;
                        end
                    pms_pkg::ST_STOPPED:
                    begin
                        motor.op_state = pms_pkg::ST_INACTIVE;
                        motor.darts    = '0;
                    end
                    default: ;
                endcase
            end
            pms_pkg::OP_START:
            begin
                motor.op_state = pms_pkg::ST_STARTING;
                motor.darts    = '0;
            end
            pms_pkg::OP_STOP:
                if (motor.op_state < pms_pkg::ST_RETURNING &&
                    !(cfg_shadow.count_target != 0 &&
                      motor.darts < 16'(cfg_shadow.count_target)))
                    motor.op_state = pms_pkg::ST_RETURNING;
            pms_pkg::OP_BACK:
                if (motor.back_quiet >= cfg_shadow.debounce_ms)
                begin
                    motor.back_quiet = '0;
                    if (!level)
                    begin
                        motor.disc_position = pms_pkg::POS_BACK;
                        if (motor.op_state == pms_pkg::ST_RETURNING)
                        begin
                            motor.op_state    = pms_pkg::ST_BRAKING;
                            motor.pin_a       = 1'b1;
                            motor.pin_b       = 1'b1;
                            motor.brake_timer = cfg_shadow.back_brake_ms;
                        end
                    end
                    else
                    begin
                        motor.disc_position = pms_pkg::POS_AFTER_BACK;
                        if (motor.op_state == pms_pkg::ST_BRAKING)
                        begin
                            motor.op_state = pms_pkg::ST_RETURNING;
                            motor.duty     = pms_pkg::SPEED_REVERSE;
                            motor.pin_a    = 1'b0;
                            motor.pin_b    = 1'b1;
                        end
                    end
                end
            pms_pkg::OP_FRONT:
                if (motor.front_quiet >= cfg_shadow.debounce_ms)
                begin
                    motor.front_quiet = '0;
                    if (!level)
                    begin
                        motor.disc_position = pms_pkg::POS_FRONT;
                        if (motor.darts != pms_pkg::DARTS_MAX)
                            motor.darts++;
                    end
                    else
                    begin
                        motor.disc_position = pms_pkg::POS_AFTER_FRONT;
                        if (motor.op_state == pms_pkg::ST_RETURNING)
                        begin
                            motor.pin_a       = 1'b1;
                            motor.pin_b       = 1'b1;
                            motor.brake_timer = cfg_shadow.front_brake_ms;
                        end
                    end
                end
            default: ;
        endcase
        r.in1     = motor.pin_a;
        r.in2     = motor.pin_b;
        r.speed   = motor.duty;
        r.standby = motor.standby_level;
        r.state   = motor.op_state;
        r.pos     = motor.disc_position;
        r.count   = motor.darts;
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(input logic [2:0] op, input logic level, input logic ready_in);
        int unsigned gap;
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= op;
        in_ch.sensor_level   <= level;
        in_ch.launcher_ready <= ready_in;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        expected_drive_q.push_back(predict_motor_step(op, level, ready_in));
        items_sent++;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                no_gap_left = $urandom_range(20, 60);
            gap = idle_len();
        end
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_drive_q.size() != 0);
    endtask

    task automatic program_regs(input logic [7:0] target, input logic [7:0] debounce,
                                input logic [7:0] back_ms, input logic [7:0] front_ms);
        logic [7:0] vals [4];
        vals = '{target, debounce, back_ms, front_ms};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cfg_shadow.count_target   = target;
        cfg_shadow.debounce_ms    = debounce[2:0];
        cfg_shadow.back_brake_ms  = back_ms;
        cfg_shadow.front_brake_ms = front_ms;
        setting_count++;
    endtask

    task automatic settle_front();
        while (motor.front_quiet < cfg_shadow.debounce_ms)
            send_item(pms_pkg::OP_TICK, rbit(), rbit());
    endtask

    task automatic settle_back();
        while (motor.back_quiet < cfg_shadow.debounce_ms)
            send_item(pms_pkg::OP_TICK, rbit(), rbit());
    endtask

    task automatic maybe_noise(input bit noisy);
        logic [2:0] op;
        if (!noisy || $urandom_range(0, 11) != 0)
            return;
        op = 3'($urandom_range(0, 7));
        if (op == pms_pkg::OP_START)
            op = pms_pkg::OP_STOP;
        send_item(op, rbit(), rbit());
    endtask

    // Steers the sequencer back to inactive: stop, reach the back sensor, wait out the brake.
    task automatic bring_home(input bit noisy, input bit overshoot);
        int unsigned guard;
        guard = 0;
        while (motor.op_state != pms_pkg::ST_INACTIVE && guard < HOME_GUARD)
        begin
            guard++;
            case (motor.op_state)
                pms_pkg::ST_STARTING, pms_pkg::ST_RUNNING:
                    if (cfg_shadow.count_target != 0 &&
                        motor.darts < 16'(cfg_shadow.count_target))
                    begin
                        settle_front();
                        send_item(pms_pkg::OP_FRONT, 1'b0, rbit());
                    end
                    else
                        send_item(pms_pkg::OP_STOP, rbit(), rbit());
                pms_pkg::ST_RETURNING:
                    if (motor.disc_position == pms_pkg::POS_UNKNOWN ||
                        motor.disc_position == pms_pkg::POS_AFTER_FRONT)
                        send_item(pms_pkg::OP_TICK, rbit(), rbit());
                    else
                    begin
                        settle_back();
                        send_item(pms_pkg::OP_BACK, 1'b0, rbit());
                    end
                pms_pkg::ST_BRAKING:
                    if (motor.disc_position != pms_pkg::POS_BACK)
                    begin
                        settle_back();
                        send_item(pms_pkg::OP_BACK, 1'b0, rbit());
                    end
                    else if (overshoot)
                    begin
                        // disc runs past the back sensor: released while still braking
                        overshoot = 1'b0;
                        settle_back();
                        send_item(pms_pkg::OP_BACK, 1'b1, rbit());
                    end
                    else
                        send_item(pms_pkg::OP_TICK, rbit(), rbit());
                default:
                    send_item(pms_pkg::OP_TICK, rbit(), rbit());
            endcase
            maybe_noise(noisy);
        end
    endtask

    task automatic run_burst(input int unsigned n_darts, input bit noisy, input bit overshoot,
                             input bit stop_early);
        burst_count++;
        send_item(pms_pkg::OP_START, rbit(), rbit());
        while (motor.op_state == pms_pkg::ST_STARTING)
            send_item(pms_pkg::OP_TICK, rbit(), rbit());
        if (stop_early)
            send_item(pms_pkg::OP_STOP, rbit(), rbit());
        repeat (n_darts)
        begin
            settle_front();
            send_item(pms_pkg::OP_FRONT, 1'b0, rbit());
            maybe_noise(noisy);
            settle_front();
            send_item(pms_pkg::OP_FRONT, 1'b1, rbit());
            maybe_noise(noisy);
        end
        send_item(pms_pkg::OP_STOP, rbit(), rbit());
        if (motor.op_state == pms_pkg::ST_RETURNING)
        begin
            settle_front();
            send_item(pms_pkg::OP_FRONT, 1'b1, rbit());
        end
        bring_home(noisy, overshoot);
    endtask

    // Sensors are ignored until their quiet counters reach the debounce setting; stop is ignored while returning.
    task automatic test_after_reset();
        send_item(pms_pkg::OP_BACK, 1'b0, 1'b1);
        send_item(pms_pkg::OP_FRONT, 1'b0, 1'b0);
        send_item(pms_pkg::OP_STOP, 1'b1, 1'b1);
        for (logic [3:0] op = {1'b0, OP_UNUSED_LO}; op <= {1'b0, OP_UNUSED_HI}; op++)
            send_item(op[2:0], rbit(), rbit());
        send_item(pms_pkg::OP_TICK, 1'b0, 1'b0);
        send_item(pms_pkg::OP_FRONT, 1'b1, 1'b1);
        send_item(pms_pkg::OP_BACK, 1'b1, 1'b0);
        bring_home(1'b0, 1'b0);
    endtask

    task automatic test_run_until_stop();
        wait_results_drained();
        program_regs(8'd0, 8'd1, 8'd0, 8'd0);
        run_burst(2, 1'b0, 1'b1, 1'b0);
        // stop from inactive, then start while returning
        send_item(pms_pkg::OP_STOP, 1'b0, 1'b0);
        send_item(pms_pkg::OP_START, 1'b1, 1'b0);
        send_item(pms_pkg::OP_TICK, 1'b0, 1'b0);
        send_item(pms_pkg::OP_TICK, 1'b1, 1'b1);
        bring_home(1'b0, 1'b0);
    endtask

    task automatic test_count_target();
        wait_results_drained();
        program_regs(8'd2, 8'd7, 8'd255, 8'd3);
        run_burst(2, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_debounce_zero();
        wait_results_drained();
        program_regs(8'd0, 8'd0, 8'd1, 8'd255);
        send_item(pms_pkg::OP_BACK, 1'b0, 1'b0);
        send_item(pms_pkg::OP_BACK, 1'b1, 1'b1);
        send_item(pms_pkg::OP_BACK, 1'b0, 1'b0);
        send_item(pms_pkg::OP_FRONT, 1'b0, 1'b1);
        send_item(pms_pkg::OP_FRONT, 1'b0, 1'b0);
        send_item(pms_pkg::OP_FRONT, 1'b1, 1'b1);
        run_burst(1, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_backpressure();
        wait_results_drained();
        hold_req    = 1'b1;
        no_gap_left = 40;
        repeat (40)
            send_item(3'($urandom_range(0, 7)), rbit(), rbit());
        bring_home(1'b0, 1'b0);
    endtask

    task automatic test_random_bursts();
        int unsigned stop_at;
        int unsigned r;
        logic [7:0]  target;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wait_results_drained();
                r = $urandom_range(0, 99);
                target = (r < 40) ? 8'd0 : 8'($urandom_range(1, 4));
                program_regs(target, 8'($urandom_range(0, 255)),
                             ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 12)),
                             ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 12)));
            end
            if ($urandom_range(0, 9) == 0)
                repeat (20)
                    send_item(3'($urandom_range(0, 7)), rbit(), rbit());
            else
                run_burst(cfg_shadow.count_target + $urandom_range(0, 3), 1'b1, rbit(), rbit());
        end
        bring_home(1'b0, 1'b0);
    endtask

    initial
    begin : result_checker
        drive_result_t want;
        int unsigned   stall_left;
        int unsigned   calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (expected_drive_q.size() == 0)
                begin
                    $display("%0t: result with no item pending", $time);
                    error_count++;
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    compare_field("drive_in1", 16'(want.in1), 16'(out_ch.drive_in1));
                    compare_field("drive_in2", 16'(want.in2), 16'(out_ch.drive_in2));
                    compare_field("drive_speed", 16'(want.speed), 16'(out_ch.drive_speed));
                    compare_field("standby_out", 16'(want.standby), 16'(out_ch.standby_out));
                    compare_field("operating_state", 16'(want.state),
                                  16'(out_ch.operating_state));
                    compare_field("position_code", 16'(want.pos), 16'(out_ch.position_code));
                    compare_field("dart_count", want.count, out_ch.dart_count);
                    results_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                hold_count++;
                stall_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_ch.ready <= 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    calm_left = $urandom_range(20, 60);
                stall_left = ($urandom_range(0, 5) == 0) ? idle_len() : 0;
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end
                else
                    out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.operation      <= pms_pkg::OP_TICK;
        in_ch.sensor_level   <= 1'b0;
        in_ch.launcher_ready <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= pms_pkg::CFG_COUNT_TARGET;
        cfg_data             <= '0;
        cfg_shadow = '{pms_pkg::COUNT_TARGET_RESET, pms_pkg::DEBOUNCE_RESET,
                       pms_pkg::BACK_BRAKE_RESET, pms_pkg::FRONT_BRAKE_RESET};
        motor = '{op_state: pms_pkg::ST_RETURNING, disc_position: pms_pkg::POS_UNKNOWN,
                  darts: '0, brake_timer: '0, back_quiet: '0, front_quiet: '0,
                  pin_a: 1'b0, pin_b: 1'b0, duty: '0, standby_level: 1'b1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_run_until_stop();
        test_count_target();
        test_debounce_zero();
        test_backpressure();
        test_random_bursts();

        wait_results_drained();
        repeat (4) @(posedge clk);
        if (expected_drive_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_drive_q.size());
            error_count++;
        end
        $display("Checked %0d results from %0d items: %0d bursts over %0d register settings,",
                 results_checked, items_sent, burst_count, setting_count);
        $display("with debounce extremes, long brake timers, overshoot and %0d output holds.",
                 hold_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
